// File: hdl/blst_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and sizes for the Bresenham line stepper.
// No dependencies; used by every module of the block.
package blst_pkg;

  localparam int MAX_DIM    = 4096;
  localparam int COORD_W    = $clog2(MAX_DIM);      // stored coordinate width
  localparam int CFG_W      = 13;                   // width of a config register
  localparam int IN_W       = 16;                   // endpoint field width
  localparam int DX_W       = IN_W + 1;
  localparam int DY_W       = IN_W + 2;
  localparam int ERR_W      = IN_W + 3;
  localparam int COLOR_W    = 32;
  localparam int PIX_W      = 12;                   // output pixel field width
  localparam int CFG_IDX_W  = 1;

  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);
  localparam int OQ_DEPTH   = 2;
  localparam int OQ_AW      = $clog2(OQ_DEPTH);
  localparam int OQ_CW      = $clog2(OQ_DEPTH + 1);

  localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(1920);
  localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(1080);

  // input action codes
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = CFG_IDX_W'(1);

  // result status codes
  localparam logic [1:0] ST_PIXEL  = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_IDLE   = 2'd2;

  // command kinds decided by the front end
  localparam logic [1:0] KIND_START  = 2'd0;
  localparam logic [1:0] KIND_REJECT = 2'd1;
  localparam logic [1:0] KIND_STEP   = 2'd2;

  typedef struct packed {
    logic [1:0]                kind;
    logic [COORD_W-1:0]        x0;
    logic [COORD_W-1:0]        y0;
    logic [COORD_W-1:0]        x1;
    logic [COORD_W-1:0]        y1;
    logic                      sxn;
    logic                      syn;
    logic [DX_W-1:0]           dx;
    logic signed [DY_W-1:0]    dy;
    logic signed [ERR_W-1:0]   err;
    logic [COLOR_W-1:0]        color;
  } cmd_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [PIX_W-1:0]    px;
    logic [PIX_W-1:0]    py;
    logic [COLOR_W-1:0]  color;
    logic                last;
  } res_t;

endpackage

// File: hdl/blst_front.sv
`timescale 1ns / 1ps
// Front end: image size registers, endpoint bounds check and line setup.
// Depends on blst_pkg.
module blst_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [blst_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [blst_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                                in_action,
  input  logic signed [blst_pkg::IN_W-1:0]    in_start_x,
  input  logic signed [blst_pkg::IN_W-1:0]    in_start_y,
  input  logic signed [blst_pkg::IN_W-1:0]    in_end_x,
  input  logic signed [blst_pkg::IN_W-1:0]    in_end_y,
  input  logic [blst_pkg::COLOR_W-1:0]        in_color,
  output blst_pkg::cmd_t                      cmd_o
);

  localparam logic [blst_pkg::CFG_W-1:0] DIM_CAP = blst_pkg::CFG_W'(blst_pkg::MAX_DIM);

  logic [blst_pkg::CFG_W-1:0]           width_r, height_r;
  logic [blst_pkg::CFG_W-1:0]           w_eff, h_eff;
  logic                                 out0, out1;
  logic signed [blst_pkg::DX_W-1:0]     diff_x;
  logic signed [blst_pkg::DX_W-1:0]     diff_y;
  logic [blst_pkg::DX_W-1:0]            abs_x, abs_y;
  logic signed [blst_pkg::DY_W-1:0]     dy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= blst_pkg::WIDTH_RST;
      height_r <= blst_pkg::HEIGHT_RST;
    end else if (cfg_we) begin
      if (cfg_idx == blst_pkg::CFG_IDX_WIDTH)  width_r  <= cfg_wdata;
      if (cfg_idx == blst_pkg::CFG_IDX_HEIGHT) height_r <= cfg_wdata;
    end
  end

  always_comb begin
    w_eff = (width_r  > DIM_CAP) ? DIM_CAP : width_r;
    h_eff = (height_r > DIM_CAP) ? DIM_CAP : height_r;

    // negative coordinates fail on the sign bit, the rest compare unsigned
    out0 = in_start_x[blst_pkg::IN_W-1] || in_start_y[blst_pkg::IN_W-1] ||
           (unsigned'(in_start_x) >= blst_pkg::IN_W'(w_eff)) ||
           (unsigned'(in_start_y) >= blst_pkg::IN_W'(h_eff));
    out1 = in_end_x[blst_pkg::IN_W-1] || in_end_y[blst_pkg::IN_W-1] ||
           (unsigned'(in_end_x) >= blst_pkg::IN_W'(w_eff)) ||
           (unsigned'(in_end_y) >= blst_pkg::IN_W'(h_eff));

    diff_x = blst_pkg::DX_W'(in_end_x) - blst_pkg::DX_W'(in_start_x);
    diff_y = blst_pkg::DX_W'(in_end_y) - blst_pkg::DX_W'(in_start_y);
    abs_x  = diff_x[blst_pkg::DX_W-1] ? unsigned'(-diff_x) : unsigned'(diff_x);
    abs_y  = diff_y[blst_pkg::DX_W-1] ? unsigned'(-diff_y) : unsigned'(diff_y);
    dy     = -signed'({1'b0, abs_y});

    if (in_action == blst_pkg::ACT_STEP) cmd_o.kind = blst_pkg::KIND_STEP;
    else if (out0 || out1)               cmd_o.kind = blst_pkg::KIND_REJECT;
    else                                 cmd_o.kind = blst_pkg::KIND_START;

    cmd_o.x0    = in_start_x[blst_pkg::COORD_W-1:0];
    cmd_o.y0    = in_start_y[blst_pkg::COORD_W-1:0];
    cmd_o.x1    = in_end_x[blst_pkg::COORD_W-1:0];
    cmd_o.y1    = in_end_y[blst_pkg::COORD_W-1:0];
    cmd_o.sxn   = !(in_start_x < in_end_x);
    cmd_o.syn   = !(in_start_y < in_end_y);
    cmd_o.dx    = abs_x;
    cmd_o.dy    = dy;
    cmd_o.err   = signed'({2'b00, abs_x}) + blst_pkg::ERR_W'(dy);
    cmd_o.color = in_color;
  end

endmodule

// File: hdl/blst_cmd_q.sv
`timescale 1ns / 1ps
// Short command queue between the front end and the line walker.
// Depends on blst_pkg.
module blst_cmd_q (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_i,
  input  blst_pkg::cmd_t  data_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            empty_o,
  output blst_pkg::cmd_t  head_o
);

  localparam logic [blst_pkg::CMDQ_CW-1:0] DEPTH_C = blst_pkg::CMDQ_CW'(blst_pkg::CMDQ_DEPTH);
  localparam logic [blst_pkg::CMDQ_AW-1:0] LAST_C  =
    blst_pkg::CMDQ_AW'(blst_pkg::CMDQ_DEPTH - 1);

  blst_pkg::cmd_t                     mem [blst_pkg::CMDQ_DEPTH];
  logic [blst_pkg::CMDQ_AW-1:0]       wr_r, rd_r;
  logic [blst_pkg::CMDQ_CW-1:0]       cnt_r;

  assign full_o  = (cnt_r == DEPTH_C);
  assign empty_o = (cnt_r == '0);
  assign head_o  = mem[rd_r];

  always_ff @(posedge clk) begin
    if (push_i) mem[wr_r] <= data_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push_i) wr_r <= (wr_r == LAST_C) ? '0 : wr_r + 1'b1;
      if (pop_i)  rd_r <= (rd_r == LAST_C) ? '0 : rd_r + 1'b1;
      if (push_i && !pop_i)      cnt_r <= cnt_r + 1'b1;
      else if (!push_i && pop_i) cnt_r <= cnt_r - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> (!full_o || pop_i))
    else $error("command queue written while full");

endmodule

// File: hdl/blst_back.sv
`timescale 1ns / 1ps
// Back end: walker state, at most one Bresenham move per command, result queue.
// Depends on blst_pkg.
module blst_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cq_empty_i,
  input  blst_pkg::cmd_t                     cmd_i,
  output logic                               cq_pop_o,
  input  logic                               pop,
  output logic                               empty,
  output blst_pkg::res_t                     res_o
);

  localparam int CW = blst_pkg::COORD_W;
  localparam int EW = blst_pkg::ERR_W;
  localparam logic [blst_pkg::OQ_CW-1:0] OQ_FULL = blst_pkg::OQ_CW'(blst_pkg::OQ_DEPTH);
  localparam logic [blst_pkg::OQ_AW-1:0] OQ_LAST = blst_pkg::OQ_AW'(blst_pkg::OQ_DEPTH - 1);

  typedef struct packed {
    logic                 brk;
    logic [CW-1:0]        x;
    logic [CW-1:0]        y;
    logic signed [EW-1:0] e;
  } adv_t;

  // One walker move; brk is set when the line cannot continue from (x, y).
  function automatic adv_t advance(
    input logic [CW-1:0]                    x,
    input logic [CW-1:0]                    y,
    input logic signed [EW-1:0]             e,
    input logic [CW-1:0]                    tx,
    input logic [CW-1:0]                    ty,
    input logic [blst_pkg::DX_W-1:0]        dx,
    input logic signed [blst_pkg::DY_W-1:0] dy,
    input logic                             sxn,
    input logic                             syn
  );
    adv_t                 r;
    logic signed [EW:0]   ew;
    logic signed [EW+1:0] e2;
    logic signed [EW+1:0] dx2;
    logic signed [EW+1:0] dy2;
    r.brk = 1'b0;
    r.x   = x;
    r.y   = y;
    ew    = (EW + 1)'(e);
    dx2   = signed'({4'b0000, dx});
    dy2   = (EW + 2)'(dy);
    if (x == tx && y == ty) begin
      r.brk = 1'b1;
    end else begin
      e2 = {ew, 1'b0};
      if (e2 >= dy2) begin
        if (x == tx) begin
          r.brk = 1'b1;
        end else begin
          ew  = ew + (EW + 1)'(dy);
          r.x = sxn ? x - 1'b1 : x + 1'b1;
        end
      end
      if (!r.brk) begin
        e2 = {ew, 1'b0};
        if (e2 <= dx2) begin
          if (y == ty) begin
            r.brk = 1'b1;
          end else begin
            ew  = ew + signed'({3'b000, dx});
            r.y = syn ? y - 1'b1 : y + 1'b1;
          end
        end
      end
    end
    r.e = ew[EW-1:0];
    return r;
  endfunction

  // line state; cand_* holds the move after the last pixel sent
  logic                              active_r;
  logic [CW-1:0]                     cand_x_r, cand_y_r, tgt_x_r, tgt_y_r;
  logic signed [EW-1:0]              cand_e_r;
  logic                              sxn_r, syn_r;
  logic [blst_pkg::DX_W-1:0]         dx_r;
  logic signed [blst_pkg::DY_W-1:0]  dy_r;
  logic [blst_pkg::COLOR_W-1:0]      color_r;

  blst_pkg::res_t                    oq_mem [blst_pkg::OQ_DEPTH];
  logic [blst_pkg::OQ_AW-1:0]        oq_wr_r, oq_rd_r;
  logic [blst_pkg::OQ_CW-1:0]        oq_cnt_r;

  logic                              is_start, fire, out_fire;
  adv_t                              adv;
  blst_pkg::res_t                    res_nxt;

  assign empty    = (oq_cnt_r == '0);
  assign res_o    = oq_mem[oq_rd_r];
  assign out_fire = pop && !empty;
  assign fire     = !cq_empty_i && ((oq_cnt_r != OQ_FULL) || out_fire);
  assign cq_pop_o = fire;
  assign is_start = (cmd_i.kind == blst_pkg::KIND_START);

  always_comb begin
    if (is_start)
      adv = advance(cmd_i.x0, cmd_i.y0, cmd_i.err, cmd_i.x1, cmd_i.y1,
                    cmd_i.dx, cmd_i.dy, cmd_i.sxn, cmd_i.syn);
    else
      adv = advance(cand_x_r, cand_y_r, cand_e_r, tgt_x_r, tgt_y_r,
                    dx_r, dy_r, sxn_r, syn_r);

    res_nxt = '0;
    case (cmd_i.kind)
      blst_pkg::KIND_START: begin
        res_nxt.status = blst_pkg::ST_PIXEL;
        res_nxt.px     = blst_pkg::PIX_W'(cmd_i.x0);
        res_nxt.py     = blst_pkg::PIX_W'(cmd_i.y0);
        res_nxt.color  = cmd_i.color;
        res_nxt.last   = adv.brk;
      end
      blst_pkg::KIND_REJECT: begin
        res_nxt.status = blst_pkg::ST_REJECT;
      end
      blst_pkg::KIND_STEP: begin
        if (active_r) begin
          res_nxt.status = blst_pkg::ST_PIXEL;
          res_nxt.px     = blst_pkg::PIX_W'(cand_x_r);
          res_nxt.py     = blst_pkg::PIX_W'(cand_y_r);
          res_nxt.color  = color_r;
          res_nxt.last   = adv.brk;
        end else begin
          res_nxt.status = blst_pkg::ST_IDLE;
        end
      end
      default: begin
        res_nxt.status = blst_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cand_x_r <= '0;
      cand_y_r <= '0;
      cand_e_r <= '0;
      tgt_x_r  <= '0;
      tgt_y_r  <= '0;
      sxn_r    <= 1'b0;
      syn_r    <= 1'b0;
      dx_r     <= '0;
      dy_r     <= '0;
      color_r  <= '0;
    end else if (fire) begin
      case (cmd_i.kind)
        blst_pkg::KIND_START: begin
          active_r <= !adv.brk;
          cand_x_r <= adv.x;
          cand_y_r <= adv.y;
          cand_e_r <= adv.e;
          tgt_x_r  <= cmd_i.x1;
          tgt_y_r  <= cmd_i.y1;
          sxn_r    <= cmd_i.sxn;
          syn_r    <= cmd_i.syn;
          dx_r     <= cmd_i.dx;
          dy_r     <= cmd_i.dy;
          color_r  <= cmd_i.color;
        end
        blst_pkg::KIND_REJECT: begin
          active_r <= 1'b0;
        end
        blst_pkg::KIND_STEP: begin
          if (active_r) begin
            active_r <= !adv.brk;
            cand_x_r <= adv.x;
            cand_y_r <= adv.y;
            cand_e_r <= adv.e;
          end
        end
        default: begin
          active_r <= active_r;
        end
      endcase
    end
  end

  // result queue
  always_ff @(posedge clk) begin
    if (fire) oq_mem[oq_wr_r] <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (fire)     oq_wr_r <= (oq_wr_r == OQ_LAST) ? '0 : oq_wr_r + 1'b1;
      if (out_fire) oq_rd_r <= (oq_rd_r == OQ_LAST) ? '0 : oq_rd_r + 1'b1;
      if (fire && !out_fire)      oq_cnt_r <= oq_cnt_r + 1'b1;
      else if (!fire && out_fire) oq_cnt_r <= oq_cnt_r - 1'b1;
    end
  end

  a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res_nxt.status == blst_pkg::ST_PIXEL && res_nxt.last) |=> !active_r)
    else $error("line still active after its last pixel");

  a_idle_when_inactive: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && cmd_i.kind == blst_pkg::KIND_STEP && !active_r)
      |-> res_nxt.status == blst_pkg::ST_IDLE)
    else $error("step without a line did not report idle");

  a_oq_room: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> (oq_cnt_r != OQ_FULL || out_fire))
    else $error("result queue overrun");

endmodule

// File: hdl/bresenham_line_stepper.sv
`timescale 1ns / 1ps
// Top level of the all-octant Bresenham line stepper.
// Depends on blst_pkg, blst_front, blst_cmd_q and blst_back.
//
// Usage:
//   Input queue: drive the in_* fields and raise push; a transaction is
//   taken at an edge where push is high and full is low. action 0 starts a
//   line (endpoints and color), action 1 asks for the next pixel.
//   Result queue: while empty is low the oldest result sits on the out_*
//   ports; it is taken at an edge where pop is high. Every input transaction
//   gives exactly one result: a pixel, a rejected start, or idle.
//   Config: cfg_we writes cfg_wdata into image_width (index 0) or
//   image_height (index 1) at the edge; write only while the block is idle.
// Timing:
//   Each input is held in the command queue and its result in the result
//   queue before it reaches the out ports. Throughput is one item per
//   cycle while the result queue has room; the walker does one error-term
//   move per cycle with the line setup done in the front end.
// Reset (synchronous, rst_n low): no line active, image size 1920 x 1080,
// both queues empty. When the receiver stops popping, the two-entry result
// queue fills, the walker halts, the two-entry command queue fills and
// full rises; nothing is dropped.
module bresenham_line_stepper (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [blst_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [blst_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                                push,
  output logic                                full,
  input  logic                                in_action,
  input  logic signed [blst_pkg::IN_W-1:0]    in_start_x,
  input  logic signed [blst_pkg::IN_W-1:0]    in_start_y,
  input  logic signed [blst_pkg::IN_W-1:0]    in_end_x,
  input  logic signed [blst_pkg::IN_W-1:0]    in_end_y,
  input  logic [blst_pkg::COLOR_W-1:0]        in_color,
  output logic                                empty,
  input  logic                                pop,
  output logic [1:0]                          out_status,
  output logic [blst_pkg::PIX_W-1:0]          out_pixel_x,
  output logic [blst_pkg::PIX_W-1:0]          out_pixel_y,
  output logic [blst_pkg::COLOR_W-1:0]        out_pixel_color,
  output logic                                out_last
);

  blst_pkg::cmd_t cmd_in, cmd_head;
  blst_pkg::res_t res;
  logic           cq_empty, cq_pop, cq_push;

  assign cq_push = push && !full;

  blst_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .in_action  (in_action),
    .in_start_x (in_start_x),
    .in_start_y (in_start_y),
    .in_end_x   (in_end_x),
    .in_end_y   (in_end_y),
    .in_color   (in_color),
    .cmd_o      (cmd_in)
  );

  blst_cmd_q u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (cq_push),
    .data_i  (cmd_in),
    .pop_i   (cq_pop),
    .full_o  (full),
    .empty_o (cq_empty),
    .head_o  (cmd_head)
  );

  blst_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cq_empty_i (cq_empty),
    .cmd_i      (cmd_head),
    .cq_pop_o   (cq_pop),
    .pop        (pop),
    .empty      (empty),
    .res_o      (res)
  );

  assign out_status      = res.status;
  assign out_pixel_x     = res.px;
  assign out_pixel_y     = res.py;
  assign out_pixel_color = res.color;
  assign out_last        = res.last;

endmodule

// File: tb/tb_bresenham_line_stepper.sv
`timescale 1ns / 1ps
// Self-checking testbench for bresenham_line_stepper: queued driver and monitor
// with a cycle-free line walker predictor. Depends on blst_pkg and the block.
module tb_bresenham_line_stepper;
  import blst_pkg::*;

  localparam int HOLD_CYCLES    = 80;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    logic                   action;
    logic signed [IN_W-1:0] sx;
    logic signed [IN_W-1:0] sy;
    logic signed [IN_W-1:0] ex;
    logic signed [IN_W-1:0] ey;
    logic [COLOR_W-1:0]     color;
  } line_cmd_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx = CFG_IDX_WIDTH;
  logic [CFG_W-1:0]       cfg_wdata = '0;
  logic                   push = 1'b0;
  logic                   full;
  logic                   in_action = ACT_STEP;
  logic signed [IN_W-1:0] in_start_x = '0;
  logic signed [IN_W-1:0] in_start_y = '0;
  logic signed [IN_W-1:0] in_end_x = '0;
  logic signed [IN_W-1:0] in_end_y = '0;
  logic [COLOR_W-1:0]     in_color = '0;
  logic                   empty;
  logic                   pop = 1'b0;
  logic [1:0]             out_status;
  logic [PIX_W-1:0]       out_pixel_x;
  logic [PIX_W-1:0]       out_pixel_y;
  logic [COLOR_W-1:0]     out_pixel_color;
  logic                   out_last;

  bresenham_line_stepper uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .push(push), .full(full),
    .in_action(in_action), .in_start_x(in_start_x), .in_start_y(in_start_y),
    .in_end_x(in_end_x), .in_end_y(in_end_y), .in_color(in_color),
    .empty(empty), .pop(pop),
    .out_status(out_status), .out_pixel_x(out_pixel_x), .out_pixel_y(out_pixel_y),
    .out_pixel_color(out_pixel_color), .out_last(out_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  line_cmd_t line_cmds_q[$];
  res_t      pixel_out_q[$];

  int  n_total, n_done, err_cnt, quiet_cycles, n_cfg;
  int  n_pix, n_rej, n_idle, n_last;
  int  send_idle_pct, recv_stall_pct;
  int  hold_gen, hold_seen, hold_left;
  bit  in_took;

  // walker state
  int unsigned img_w = 1920;
  int unsigned img_h = 1080;
  bit          line_on;
  int          cx, cy, tx, ty, dlx, dly, err;
  bit          xneg, yneg;
  logic [COLOR_W-1:0] lcolor;

  function automatic int mag(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int eff_dim(int unsigned v);
    return (v > MAX_DIM) ? MAX_DIM : int'(v);
  endfunction

  function automatic bit off_image(int x, int y);
    return x < 0 || y < 0 || x >= eff_dim(img_w) || y >= eff_dim(img_h);
  endfunction

  // one error-rule move; returns 1 when the walk cannot go on
  function automatic bit walk_move(inout int x, inout int y, inout int e);
    if (x == tx && y == ty) return 1'b1;
    if (2 * e >= dly) begin
      if (x == tx) return 1'b1;
      e += dly;
      x += xneg ? -1 : 1;
    end
    if (2 * e <= dlx) begin
      if (y == ty) return 1'b1;
      e += dlx;
      y += yneg ? -1 : 1;
    end
    return 1'b0;
  endfunction

  function automatic res_t emit_pixel();
    int   x, y, e;
    bit   fin;
    res_t r;
    x = cx;
    y = cy;
    e = err;
    fin = walk_move(x, y, e);
    r.status = ST_PIXEL;
    r.px = cx[PIX_W-1:0];
    r.py = cy[PIX_W-1:0];
    r.color = lcolor;
    r.last = fin;
    if (fin) line_on = 1'b0;
    return r;
  endfunction

  function automatic res_t walk_line_cmd(line_cmd_t c);
    res_t r;
    int   x0, y0, x1, y1;
    r = '0;
    if (c.action == ACT_START) begin
      x0 = c.sx;
      y0 = c.sy;
      x1 = c.ex;
      y1 = c.ey;
      line_on = 1'b0;
      if (off_image(x0, y0) || off_image(x1, y1)) begin
        r.status = ST_REJECT;
        return r;
      end
      cx = x0;
      cy = y0;
      tx = x1;
      ty = y1;
      xneg = !(x0 < x1);
      yneg = !(y0 < y1);
      dlx = mag(x1 - x0);
      dly = -mag(y1 - y0);
      err = dlx + dly;
      lcolor = c.color;
      line_on = 1'b1;
      return emit_pixel();
    end
    if (!line_on) begin
      r.status = ST_IDLE;
      return r;
    end
    void'(walk_move(cx, cy, err));
    return emit_pixel();
  endfunction

  task automatic cmp_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endtask

  // input side: present queued transactions, hold each until taken
  always @(negedge clk) begin : drive_cmds
    line_cmd_t c;
    if (!rst_n) begin
      push <= 1'b0;
    end else if (push && !in_took) begin
      // still waiting for the block to take it
    end else if (line_cmds_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
      c = line_cmds_q.pop_front();
      push <= 1'b1;
      in_action <= c.action;
      in_start_x <= c.sx;
      in_start_y <= c.sy;
      in_end_x <= c.ex;
      in_end_y <= c.ey;
      in_color <= c.color;
    end else begin
      push <= 1'b0;
    end
  end

  // result side: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (hold_gen != hold_seen) begin
      hold_seen <= hold_gen;
      hold_left <= HOLD_CYCLES;
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : watch
    line_cmd_t got;
    res_t      want;
    bit        moved;
    moved = 1'b0;
    if (rst_n) begin
      in_took <= push && !full;
      if (pop && !empty) begin
        moved = 1'b1;
        if (pixel_out_q.size() == 0) begin
          $error("result transaction with nothing expected: status %0d", out_status);
          err_cnt++;
        end else begin
          want = pixel_out_q.pop_front();
          cmp_field("status", want.status, out_status);
          cmp_field("pixel_x", want.px, out_pixel_x);
          cmp_field("pixel_y", want.py, out_pixel_y);
          cmp_field("pixel_color", want.color, out_pixel_color);
          cmp_field("last", want.last, out_last);
          if (want.status == ST_PIXEL) n_pix++;
          if (want.status == ST_REJECT) n_rej++;
          if (want.status == ST_IDLE) n_idle++;
          if (want.status == ST_PIXEL && want.last) n_last++;
        end
      end
      if (push && !full) begin
        moved = 1'b1;
        got.action = in_action;
        got.sx = in_start_x;
        got.sy = in_start_y;
        got.ex = in_end_x;
        got.ey = in_end_y;
        got.color = in_color;
        pixel_out_q.push_back(walk_line_cmd(got));
        n_done++;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic line_cmd_t mk_start(int x0, int y0, int x1, int y1,
                                         logic [COLOR_W-1:0] col);
    line_cmd_t c;
    c.action = ACT_START;
    c.sx = x0[IN_W-1:0];
    c.sy = y0[IN_W-1:0];
    c.ex = x1[IN_W-1:0];
    c.ey = y1[IN_W-1:0];
    c.color = col;
    return c;
  endfunction

  // endpoint and color fields of a step are don't-care, so randomize them
  function automatic line_cmd_t mk_step();
    line_cmd_t c;
    c = mk_start($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    c.action = ACT_STEP;
    return c;
  endfunction

  task automatic add_cmd(line_cmd_t c);
    line_cmds_q.push_back(c);
    n_total++;
  endtask

  function automatic int rand16();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic int clamp_to(int v, int hi);
    return (v < 0) ? 0 : (v > hi) ? hi : v;
  endfunction

  task automatic add_random_line(int ew, int eh);
    int kind, x0, y0, x1, y1, len, steps;
    kind = $urandom_range(0, 99);
    if (kind < 5) add_cmd(mk_step());
    if (ew == 0 || eh == 0 || kind < 12) begin
      x0 = rand16();
      y0 = rand16();
      x1 = rand16();
      y1 = rand16();
      if (ew > 0 && eh > 0 && kind % 2 == 1) begin
        // in the image except for one coordinate just past an edge
        x0 = $urandom_range(0, ew - 1);
        y0 = $urandom_range(0, eh - 1);
        x1 = $urandom_range(0, ew - 1);
        y1 = $urandom_range(0, eh - 1);
        case ($urandom_range(0, 3))
          0: x1 = ew;
          1: y1 = eh;
          2: x0 = -1;
          default: y0 = -1;
        endcase
      end
      add_cmd(mk_start(x0, y0, x1, y1, $urandom()));
      steps = $urandom_range(0, 2);
    end else begin
      x0 = $urandom_range(0, ew - 1);
      y0 = $urandom_range(0, eh - 1);
      if (kind < 75) begin
        x1 = clamp_to(x0 + int'($urandom_range(0, 24)) - 12, ew - 1);
        y1 = clamp_to(y0 + int'($urandom_range(0, 24)) - 12, eh - 1);
      end else begin
        x1 = $urandom_range(0, ew - 1);
        y1 = $urandom_range(0, eh - 1);
      end
      len = (mag(x1 - x0) > mag(y1 - y0)) ? mag(x1 - x0) : mag(y1 - y0);
      // long lines are cut short by the next start
      steps = (len > 40) ? $urandom_range(0, 40) : len + $urandom_range(0, 2);
      add_cmd(mk_start(x0, y0, x1, y1, $urandom()));
    end
    repeat (steps) add_cmd(mk_step());
  endtask

  task automatic fill_random(int n);
    int stop_at;
    stop_at = n_total + n;
    while (n_total < stop_at) add_random_line(eff_dim(img_w), eff_dim(img_h));
  endtask

  task automatic add_directed();
    add_cmd(mk_step());                                   // step with no line
    add_cmd(mk_start(0, 0, 0, 0, 32'h0000_0000));         // one-pixel line
    add_cmd(mk_step());
    add_cmd(mk_start(1919, 1079, 1915, 1077, 32'hffff_ffff));
    repeat (5) add_cmd(mk_step());                        // runs past the end
    add_cmd(mk_start(10, 10, 11, 13, 32'h5a5a_a5a5));     // steep
    repeat (3) add_cmd(mk_step());
    add_cmd(mk_start(1920, 5, 0, 0, 32'h1234_5678));      // x on the width
    add_cmd(mk_start(5, 5, 5, 1080, 32'h1234_5678));      // y on the height
    add_cmd(mk_start(-1, 0, 0, 0, 32'h1234_5678));
    add_cmd(mk_start(-32768, 32767, 32767, -32768, 32'h8000_0001));
    add_cmd(mk_step());                                   // idle after reject
    add_cmd(mk_start(100, 100, 50, 120, 32'hdead_beef));
    repeat (2) add_cmd(mk_step());
    add_cmd(mk_start(3, 3, 3, 0, 32'h0f0f_0f0f));         // drops the active line
    repeat (3) add_cmd(mk_step());
  endtask

  task automatic drain();
    while (n_done != n_total || pixel_out_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_IDX_WIDTH) img_w = val;
    else img_h = val;
    n_cfg++;
  endtask

  task automatic run_phase(int w, int h, int sidle, int rstall, int n);
    drain();
    write_cfg(CFG_IDX_WIDTH, w[CFG_W-1:0]);
    write_cfg(CFG_IDX_HEIGHT, h[CFG_W-1:0]);
    @(posedge clk);
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    fill_random(n);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    add_directed();
    drain();
    // long result hold-off while the sender keeps pushing
    @(posedge clk);
    hold_gen++;
    fill_random(300);
    run_phase(4096, 4096, 76, 0, 350);
    run_phase(8191, 1, 0, 76, 300);
    run_phase(1, 8191, 15, 15, 250);
    run_phase(0, 300, 15, 15, 40);
    run_phase($urandom_range(1, 4096), $urandom_range(1, 4096), 15, 15, 200);
    drain();
    $display("Covered %0d transactions: %0d pixels (%0d line ends), %0d rejects, %0d idle",
             n_done, n_pix, n_last, n_rej, n_idle);
    $display("across %0d image size writes, zero, one, full and oversized sizes among them",
             n_cfg);
    if (err_cnt == 0 && pixel_out_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/blst_pkg.sv
hdl/blst_front.sv
hdl/blst_cmd_q.sv
hdl/blst_back.sv
hdl/bresenham_line_stepper.sv
tb/tb_bresenham_line_stepper.sv
